// ----- rtl/avfm_pkg.sv -----
// Shared types, constants and helpers for the voice fade mixer.
// No dependencies; included by every module of the block via wildcard import.
package avfm_pkg;

  localparam int GAIN_W  = 8;
  localparam int RATE_W  = 17;
  localparam int LEVEL_W = 17;
  localparam int LEN_W   = 24;
  localparam int CLIP_W  = 8;
  localparam int SAMP_W  = 16;
  localparam int ACT_W   = 3;
  localparam int FACT_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 56;

  localparam int POSITION_BITS_DEFAULT = 24;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 17'h10000;
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 8'd255;
  localparam logic [RATE_W-1:0]  FADE_RATE_RESET = 17'd7609;

  typedef enum logic [ACT_W-1:0] {
    ACT_START    = 3'd0,
    ACT_FADE_IN  = 3'd1,
    ACT_FADE_OUT = 3'd2,
    ACT_FRAME    = 3'd3,
    ACT_TICK     = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOICE_GAIN   = 1'b0,
    REG_DEFAULT_RATE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_SCALE,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;         // capture the accepted request
    logic calc_factor;  // gain x level
    logic calc_scale;   // sample x factor
    logic commit;       // update voice state, load result register
  } dp_cmd_t;

  // rates above full level clamp to full level
  function automatic logic [RATE_W-1:0] sat_rate(input logic [RATE_W-1:0] r);
    sat_rate = (r > FULL_LEVEL) ? FULL_LEVEL : r;
  endfunction

endpackage

// ----- rtl/avfm_ctrl.sv -----
// Sequencer for the voice fade mixer: steps each request through capture,
// factor multiply, sample multiply and commit. Depends on avfm_pkg.
module avfm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output avfm_pkg::dp_cmd_t cmd
);
  import avfm_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_FACTOR;
      ST_FACTOR: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_COMMIT;
      ST_COMMIT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    cmd             = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_FACTOR: cmd.calc_factor = 1'b1;
      ST_SCALE:  cmd.calc_scale  = 1'b1;
      ST_COMMIT: cmd.commit      = out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/avfm_datapath.sv -----
// Datapath for the voice fade mixer: config registers, voice state, the two
// registered multiplies, mix adders and the result register. Depends on avfm_pkg.
module avfm_datapath #(
  parameter int POSITION_BITS = avfm_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  avfm_pkg::dp_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [avfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [avfm_pkg::RATE_W-1:0]   cfg_data,
  input  logic [avfm_pkg::ACT_W-1:0]    action,
  input  logic [avfm_pkg::CLIP_W-1:0]   clip_id,
  input  logic                          loop_flag,
  input  logic                          clip_stereo,
  input  logic [avfm_pkg::LEN_W-1:0]    clip_length,
  input  logic [avfm_pkg::RATE_W-1:0]   fade_rate,
  input  logic signed [avfm_pkg::SAMP_W-1:0] src_left,
  input  logic signed [avfm_pkg::SAMP_W-1:0] src_right,
  input  logic signed [avfm_pkg::SAMP_W-1:0] mix_left,
  input  logic signed [avfm_pkg::SAMP_W-1:0] mix_right,
  output logic signed [avfm_pkg::SAMP_W-1:0] out_left,
  output logic signed [avfm_pkg::SAMP_W-1:0] out_right,
  output logic                          voice_active,
  output logic [avfm_pkg::LEVEL_W-1:0]  level_now
);
  import avfm_pkg::*;

  localparam int CMP_W  = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
  localparam int PROD_W = SAMP_W + FACT_W + 1;

  // config
  logic [GAIN_W-1:0] voice_gain;
  logic [RATE_W-1:0] default_fade_rate;

  // captured request
  logic [ACT_W-1:0]         req_action;
  logic [CLIP_W-1:0]        req_clip;
  logic                     req_loop;
  logic                     req_stereo;
  logic [LEN_W-1:0]         req_length;
  logic [RATE_W-1:0]        req_rate;
  logic signed [SAMP_W-1:0] req_src_l, req_src_r, req_mix_l, req_mix_r;

  // voice state
  logic                     active, active_next;
  logic                     looping, looping_next;
  logic [CLIP_W-1:0]        current_clip, current_clip_next;
  logic                     stereo, stereo_next;
  logic [LEN_W-1:0]         length, length_next;
  logic [POSITION_BITS-1:0] play_position, play_position_next;
  logic [LEVEL_W-1:0]       fade_level, fade_level_next;
  logic                     rising, rising_next;
  logic [RATE_W-1:0]        fade_step, fade_step_next;

  // arithmetic
  logic [GAIN_W+LEVEL_W-1:0]  gain_prod;
  logic [FACT_W-1:0]          factor;
  logic signed [PROD_W-1:0]   prod_l, prod_r;
  logic signed [SAMP_W-1:0]   sel_r;
  logic signed [SAMP_W-1:0]   sum_l, sum_r;
  logic signed [SAMP_W-1:0]   mixed_l, mixed_r;
  logic                       keep;
  logic                       plays;
  logic [POSITION_BITS-1:0]   pos_inc;
  logic [LEVEL_W:0]           level_sum;

  assign gain_prod = GAIN_W'(voice_gain) * fade_level;
  assign sel_r     = stereo ? req_src_r : req_src_l;
  // arithmetic shift by 8 lands the product back in int16 range
  assign sum_l     = req_mix_l + prod_l[SAMP_W+7:8];
  assign sum_r     = req_mix_r + prod_r[SAMP_W+7:8];
  assign keep      = req_loop && active && (req_clip == current_clip);
  assign plays     = active && (voice_gain != '0) && (fade_level != '0);
  assign pos_inc   = play_position + POSITION_BITS'(1);
  assign level_sum = {1'b0, fade_level} + {1'b0, fade_step};

  always_comb begin
    active_next        = active;
    looping_next       = looping;
    current_clip_next  = current_clip;
    stereo_next        = stereo;
    length_next        = length;
    play_position_next = play_position;
    fade_level_next    = fade_level;
    rising_next        = rising;
    fade_step_next     = fade_step;
    mixed_l            = req_mix_l;
    mixed_r            = req_mix_r;
    case (req_action)
      ACT_START: begin
        looping_next    = req_loop;
        rising_next     = 1'b1;
        fade_level_next = '0;
        fade_step_next  = default_fade_rate;
        active_next     = 1'b1;
        if (!keep) begin
          current_clip_next  = req_clip;
          stereo_next        = req_stereo;
          length_next        = req_length;
          play_position_next = '0;
        end
      end
      ACT_FADE_IN: begin
        if (req_rate == '0) fade_level_next = FULL_LEVEL;
        else                fade_step_next  = req_rate;
        rising_next = 1'b1;
      end
      ACT_FADE_OUT: begin
        if (req_rate == '0) fade_level_next = '0;
        else                fade_step_next  = req_rate;
        rising_next = 1'b0;
      end
      ACT_FRAME: begin
        if (plays) begin
          mixed_l            = sum_l;
          mixed_r            = sum_r;
          play_position_next = pos_inc;
          if (CMP_W'(pos_inc) >= CMP_W'(length)) begin
            if (looping) play_position_next = '0;
            else         active_next        = 1'b0;
          end
        end
      end
      ACT_TICK: begin
        if (active) begin
          if (rising) begin
            fade_level_next = (level_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL
                                                               : level_sum[LEVEL_W-1:0];
          end else if (fade_step > fade_level) begin
            active_next     = 1'b0;
            fade_level_next = '0;
          end else begin
            fade_level_next = fade_level - fade_step;
          end
        end
      end
      default: begin
        mixed_l = req_mix_l;
        mixed_r = req_mix_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_gain        <= GAIN_RESET;
      default_fade_rate <= FADE_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOICE_GAIN:   voice_gain        <= cfg_data[GAIN_W-1:0];
        REG_DEFAULT_RATE: default_fade_rate <= sat_rate(cfg_data);
        default:          voice_gain        <= voice_gain;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      looping       <= 1'b0;
      current_clip  <= '0;
      stereo        <= 1'b0;
      length        <= '0;
      play_position <= '0;
      fade_level    <= '0;
      rising        <= 1'b1;
      fade_step     <= '0;
    end else if (cmd.commit) begin
      active        <= active_next;
      looping       <= looping_next;
      current_clip  <= current_clip_next;
      stereo        <= stereo_next;
      length        <= length_next;
      play_position <= play_position_next;
      fade_level    <= fade_level_next;
      rising        <= rising_next;
      fade_step     <= fade_step_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_clip   <= clip_id;
      req_loop   <= loop_flag;
      req_stereo <= clip_stereo;
      req_length <= clip_length;
      req_rate   <= sat_rate(fade_rate);
      req_src_l  <= src_left;
      req_src_r  <= src_right;
      req_mix_l  <= mix_left;
      req_mix_r  <= mix_right;
    end
    if (cmd.calc_factor) begin
      // 255 x 65536 tops out below bit 24
      factor <= gain_prod[FACT_W+15:16];
    end
    if (cmd.calc_scale) begin
      prod_l <= req_src_l * $signed({1'b0, factor});
      prod_r <= sel_r * $signed({1'b0, factor});
    end
    if (cmd.commit) begin
      out_left     <= mixed_l;
      out_right    <= mixed_r;
      voice_active <= active_next;
      level_now    <= fade_level_next;
    end
  end

endmodule

// ----- rtl/audio_voice_fade_mixer.sv -----
// Top level of the voice fade mixer: stream ports, field packing, and the
// controller and datapath instances. Depends on avfm_pkg, avfm_ctrl, avfm_datapath.
//
// One playback voice. Each request (start, fade in, fade out, frame, tick) gives
// exactly one result carrying the mix after this voice plus the voice status.
// A request steps through capture, the gain x fade level multiply, the
// sample x factor multiply, and the commit of voice state and result register;
// the next request is accepted in the cycle after commit, so a new request is
// not taken before the previous one has committed. A result not yet taken
// holds the commit of the following request.
// Configuration writes are accepted in any cycle and must arrive while idle.
module audio_voice_fade_mixer #(
  parameter int POSITION_BITS = avfm_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // clip_id[7:0], loop_flag[8], clip_stereo[9], clip_length[33:10],
  // fade_rate[50:34], src_left[66:51], src_right[82:67], mix_left[98:83],
  // mix_right[114:99], zero fill[119:115]
  input  logic [avfm_pkg::IN_DATA_W-1:0]   s_tdata,
  // action[2:0]
  input  logic [avfm_pkg::ACT_W-1:0]       s_tuser,
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_left[15:0], out_right[31:16], voice_active[32], level_now[49:33],
  // zero fill[55:50]
  output logic [avfm_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [avfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avfm_pkg::RATE_W-1:0]      cfg_data
);
  import avfm_pkg::*;

  dp_cmd_t                  cmd;
  logic signed [SAMP_W-1:0] out_left, out_right;
  logic                     voice_active;
  logic [LEVEL_W-1:0]       level_now;

  assign cfg_ready = 1'b1;

  avfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  avfm_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (s_tuser),
    .clip_id      (s_tdata[7:0]),
    .loop_flag    (s_tdata[8]),
    .clip_stereo  (s_tdata[9]),
    .clip_length  (s_tdata[33:10]),
    .fade_rate    (s_tdata[50:34]),
    .src_left     (s_tdata[66:51]),
    .src_right    (s_tdata[82:67]),
    .mix_left     (s_tdata[98:83]),
    .mix_right    (s_tdata[114:99]),
    .out_left     (out_left),
    .out_right    (out_right),
    .voice_active (voice_active),
    .level_now    (level_now)
  );

  assign m_tdata = {6'b0, level_now, voice_active, out_right, out_left};

endmodule
